/* sv/tct_pkg.sv */
package tct_pkg;

    // Default store geometry.
    localparam int DEFAULT_MAX_COLUMNS = 128;
    localparam int DEFAULT_MAX_ROWS    = 32;

    // Configuration port.
    localparam int CFG_DATA_W  = 8;
    localparam int CFG_INDEX_W = 1;

    localparam logic [CFG_INDEX_W-1:0] REG_SCREEN_COLUMNS = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] REG_SCREEN_ROWS    = 1'b1;

    localparam logic [7:0] RESET_COLUMNS = 8'd80;
    localparam logic [5:0] RESET_ROWS    = 6'd25;

    // Request kinds.
    localparam logic KIND_PUT  = 1'b0;
    localparam logic KIND_READ = 1'b1;

    // Character codes with a meaning of their own.
    localparam logic [7:0] CHAR_LINE_FEED       = 8'h0A;
    localparam logic [7:0] CHAR_CARRIAGE_RETURN = 8'h0D;
    localparam logic [7:0] CHAR_BACKSPACE       = 8'h08;
    localparam logic [7:0] CHAR_TAB             = 8'h09;
    localparam logic [7:0] CHAR_SPACE           = 8'h20;

    // A tab writes this many space cells.
    localparam int TAB_CELLS = 4;

    // Depth of the queue between front and back; a power of two.
    localparam int QUEUE_DEPTH = 2;

    typedef enum logic [2:0] {
        OP_PUT_CHAR,
        OP_LINE_FEED,
        OP_CARRIAGE_RETURN,
        OP_BACKSPACE,
        OP_TAB,
        OP_READ
    } op_t;

    typedef struct packed {
        op_t        op;
        logic [7:0] char_code;
        logic [7:0] attribute;
        logic [4:0] read_row;
        logic [6:0] read_column;
    } entry_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DIV,
        ST_EXEC,
        ST_TAB,
        ST_CHECK,
        ST_MOVE,
        ST_FILL,
        ST_READ,
        ST_DONE
    } state_t;

endpackage

/* sv/tct_front.sv */
module tct_front
    import tct_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       clearing,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic       kind,
    input  logic [7:0] char_code,
    input  logic [7:0] attribute,
    input  logic [4:0] read_row,
    input  logic [6:0] read_column,
    output logic       push_valid,
    input  logic       push_ready,
    output entry_t     push_entry
);

    logic   valid_reg;
    logic   valid_next;
    entry_t entry_reg;
    entry_t entry_next;
    logic   accept;

    assign in_ready   = !clearing && (!valid_reg || push_ready);
    assign accept     = in_valid && in_ready;
    assign push_valid = valid_reg;
    assign push_entry = entry_reg;

    always_comb
    begin
        entry_next.char_code   = char_code;
        entry_next.attribute   = attribute;
        entry_next.read_row    = read_row;
        entry_next.read_column = read_column;
        if (kind == KIND_READ)
        begin
            entry_next.op = OP_READ;
        end
        else
        begin
            case (char_code)
                CHAR_LINE_FEED:       entry_next.op = OP_LINE_FEED;
                CHAR_CARRIAGE_RETURN: entry_next.op = OP_CARRIAGE_RETURN;
                CHAR_BACKSPACE:       entry_next.op = OP_BACKSPACE;
                CHAR_TAB:             entry_next.op = OP_TAB;
                default:              entry_next.op = OP_PUT_CHAR;
            endcase
        end
    end

    always_comb
    begin
        if (accept)
        begin
            valid_next = 1'b1;
        end
        else if (push_ready)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            entry_reg <= entry_next;
        end
    end

endmodule

/* sv/tct_queue.sv */
module tct_queue
    import tct_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   push_valid,
    output logic   push_ready,
    input  entry_t push_entry,
    output logic   pop_valid,
    input  logic   pop_ready,
    output entry_t pop_entry
);

    localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int NW = $clog2(QUEUE_DEPTH + 1);

    entry_t          slots [QUEUE_DEPTH];
    logic [PW-1:0]   wr_ptr_reg;
    logic [PW-1:0]   wr_ptr_next;
    logic [PW-1:0]   rd_ptr_reg;
    logic [PW-1:0]   rd_ptr_next;
    logic [NW-1:0]   count_reg;
    logic [NW-1:0]   count_next;
    logic            push;
    logic            pop;

    assign push_ready = (count_reg != NW'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_entry  = slots[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slots[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

/* sv/tct_back.sv */
module tct_back
    import tct_pkg::*;
#(
    parameter int MAX_COLUMNS = DEFAULT_MAX_COLUMNS,
    parameter int MAX_ROWS    = DEFAULT_MAX_ROWS
)
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_written,
    input  logic [$clog2(MAX_COLUMNS+1)-1:0] cols,
    input  logic [$clog2(MAX_ROWS+1)-1:0]    rows,
    input  logic                             pop_valid,
    output logic                             pop_ready,
    input  entry_t                           pop_entry,
    output logic                             clearing,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [4:0]                       cursor_row,
    output logic [6:0]                       cursor_column,
    output logic                             scrolled,
    output logic [7:0]                       cell_char,
    output logic [7:0]                       cell_attribute
);

    localparam int STORE = MAX_COLUMNS * MAX_ROWS;
    localparam int AW    = $clog2(STORE);
    localparam int NW    = AW + 1;
    localparam int CW    = $clog2(MAX_COLUMNS + 1);
    localparam int DCW   = $clog2(NW + 1);
    localparam int TBW   = $clog2(TAB_CELLS);

    state_t          state_reg;
    state_t          state_next;
    entry_t          ent_reg;
    entry_t          ent_next;
    logic [NW-1:0]   cursor_reg;
    logic [NW-1:0]   cursor_next;
    logic [NW-1:0]   row_reg;
    logic [NW-1:0]   row_next;
    logic [CW-1:0]   col_reg;
    logic [CW-1:0]   col_next;
    logic            stale_reg;
    logic            stale_next;
    logic            scrolled_reg;
    logic            scrolled_next;
    logic [15:0]     cell_reg;
    logic [15:0]     cell_next;
    logic [NW-1:0]   idx_reg;
    logic [NW-1:0]   idx_next;
    logic            pend_reg;
    logic            pend_next;
    logic [AW-1:0]   dst_reg;
    logic [AW-1:0]   dst_next;
    logic [TBW-1:0]  tab_reg;
    logic [TBW-1:0]  tab_next;
    logic [NW-1:0]   div_q_reg;
    logic [NW-1:0]   div_q_next;
    logic [CW-1:0]   div_r_reg;
    logic [CW-1:0]   div_r_next;
    logic [DCW-1:0]  div_cnt_reg;
    logic [DCW-1:0]  div_cnt_next;
    logic            out_valid_reg;
    logic            out_valid_next;
    logic [4:0]      out_row_reg;
    logic [4:0]      out_row_next;
    logic [6:0]      out_col_reg;
    logic [6:0]      out_col_next;
    logic            out_scr_reg;
    logic            out_scr_next;
    logic [15:0]     out_cell_reg;
    logic [15:0]     out_cell_next;
    logic [NW-1:0]   cells_reg;

    logic [15:0]     screen_mem [STORE];
    logic [15:0]     rdata_reg;
    logic            mem_we;
    logic [AW-1:0]   mem_waddr;
    logic [15:0]     mem_wdata;
    logic            mem_re;
    logic [AW-1:0]   mem_raddr;

    logic [NW-1:0]   cols_ext;
    logic [NW-1:0]   move_len;
    logic [NW-1:0]   move_src;
    logic [15:0]     space_cell;
    logic [CW-1:0]   col_inc;
    logic            col_wrap;
    logic            cursor_in;
    logic [CW:0]     div_trial;
    logic            div_ge;
    logic [CW:0]     div_diff;
    logic            rd_ok;
    logic [NW-1:0]   rd_lin;
    logic [NW+4:0]   row_wide;
    logic [CW+6:0]   col_wide;

    assign cols_ext   = NW'(cols);
    assign move_len   = cells_reg - cols_ext;
    assign move_src   = idx_reg + cols_ext;
    assign space_cell = {ent_reg.attribute, CHAR_SPACE};
    assign col_inc    = col_reg + 1'b1;
    assign col_wrap   = (col_inc == cols);
    assign cursor_in  = (cursor_reg < cells_reg);
    assign div_trial  = {div_r_reg, div_q_reg[NW-1]};
    assign div_ge     = (div_trial >= {1'b0, cols});
    assign div_diff   = div_trial - {1'b0, cols};
    assign rd_ok      = (32'(ent_reg.read_row) < 32'(rows))
                     && (32'(ent_reg.read_column) < 32'(cols));
    assign rd_lin     = NW'(32'(ent_reg.read_row) * 32'(cols) + 32'(ent_reg.read_column));
    assign row_wide   = {5'b0, row_reg};
    assign col_wide   = {7'b0, col_reg};

    assign clearing       = (state_reg == ST_CLEAR);
    assign pop_ready      = (state_reg == ST_IDLE);
    assign out_valid      = out_valid_reg;
    assign cursor_row     = out_row_reg;
    assign cursor_column  = out_col_reg;
    assign scrolled       = out_scr_reg;
    assign cell_char      = out_cell_reg[7:0];
    assign cell_attribute = out_cell_reg[15:8];

    always_comb
    begin
        state_next     = state_reg;
        ent_next       = ent_reg;
        cursor_next    = cursor_reg;
        row_next       = row_reg;
        col_next       = col_reg;
        stale_next     = stale_reg || cfg_written;
        scrolled_next  = scrolled_reg;
        cell_next      = cell_reg;
        idx_next       = idx_reg;
        pend_next      = pend_reg;
        dst_next       = dst_reg;
        tab_next       = tab_reg;
        div_q_next     = div_q_reg;
        div_r_next     = div_r_reg;
        div_cnt_next   = div_cnt_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_row_next   = out_row_reg;
        out_col_next   = out_col_reg;
        out_scr_next   = out_scr_reg;
        out_cell_next  = out_cell_reg;
        mem_we         = 1'b0;
        mem_waddr      = cursor_reg[AW-1:0];
        mem_wdata      = space_cell;
        mem_re         = 1'b0;
        mem_raddr      = rd_lin[AW-1:0];

        case (state_reg)
            ST_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = idx_reg[AW-1:0];
                mem_wdata = '0;
                idx_next  = idx_reg + 1'b1;
                if (idx_reg == NW'(STORE - 1))
                begin
                    state_next = ST_IDLE;
                end
            end

            ST_IDLE:
            begin
                if (pop_valid)
                begin
                    ent_next      = pop_entry;
                    scrolled_next = 1'b0;
                    cell_next     = '0;
                    if (stale_reg)
                    begin
                        // A configuration register was written, so the cursor position is
                        // split again into row and column.
                        div_q_next   = cursor_reg;
                        div_r_next   = '0;
                        div_cnt_next = '0;
                        state_next   = ST_DIV;
                    end
                    else
                    begin
                        state_next = ST_EXEC;
                    end
                end
            end

            ST_DIV:
            begin
                div_q_next   = {div_q_reg[NW-2:0], div_ge};
                div_r_next   = div_ge ? div_diff[CW-1:0] : div_trial[CW-1:0];
                div_cnt_next = div_cnt_reg + 1'b1;
                if (div_cnt_reg == DCW'(NW - 1))
                begin
                    row_next   = {div_q_reg[NW-2:0], div_ge};
                    col_next   = div_ge ? div_diff[CW-1:0] : div_trial[CW-1:0];
                    stale_next = cfg_written;
                    state_next = ST_EXEC;
                end
            end

            ST_EXEC:
            begin
                state_next = ST_CHECK;
                case (ent_reg.op)
                    OP_READ:
                    begin
                        if (rd_ok)
                        begin
                            mem_re     = 1'b1;
                            state_next = ST_READ;
                        end
                        else
                        begin
                            state_next = ST_DONE;
                        end
                    end
                    OP_LINE_FEED:
                    begin
                        cursor_next = cursor_reg + cols_ext;
                        row_next    = row_reg + 1'b1;
                    end
                    OP_CARRIAGE_RETURN:
                    begin
                        cursor_next = cursor_reg - NW'(col_reg);
                        col_next    = '0;
                    end
                    OP_BACKSPACE:
                    begin
                        if (col_reg != '0)
                        begin
                            cursor_next = cursor_reg - 1'b1;
                            col_next    = col_reg - 1'b1;
                        end
                    end
                    OP_TAB:
                    begin
                        tab_next   = '0;
                        state_next = ST_TAB;
                    end
                    default:
                    begin
                        mem_we      = cursor_in;
                        mem_wdata   = {ent_reg.attribute, ent_reg.char_code};
                        cursor_next = cursor_reg + 1'b1;
                        if (col_wrap)
                        begin
                            col_next = '0;
                            row_next = row_reg + 1'b1;
                        end
                        else
                        begin
                            col_next = col_inc;
                        end
                    end
                endcase
            end

            ST_TAB:
            begin
                // One space cell per cycle; cells past the end are dropped.
                mem_we      = cursor_in;
                cursor_next = cursor_reg + 1'b1;
                tab_next    = tab_reg + 1'b1;
                if (col_wrap)
                begin
                    col_next = '0;
                    row_next = row_reg + 1'b1;
                end
                else
                begin
                    col_next = col_inc;
                end
                if (tab_reg == TBW'(TAB_CELLS - 1))
                begin
                    state_next = ST_CHECK;
                end
            end

            ST_CHECK:
            begin
                if (!cursor_in)
                begin
                    idx_next      = '0;
                    pend_next     = 1'b0;
                    scrolled_next = 1'b1;
                    state_next    = ST_MOVE;
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end

            ST_MOVE:
            begin
                // Each cell is read one row ahead and written back in the following cycle.
                if (pend_reg)
                begin
                    mem_we    = 1'b1;
                    mem_waddr = dst_reg;
                    mem_wdata = rdata_reg;
                end
                if (idx_reg != move_len)
                begin
                    mem_re    = 1'b1;
                    mem_raddr = move_src[AW-1:0];
                    pend_next = 1'b1;
                    dst_next  = idx_reg[AW-1:0];
                    idx_next  = idx_reg + 1'b1;
                end
                else
                begin
                    pend_next = 1'b0;
                    if (!pend_reg)
                    begin
                        state_next = ST_FILL;
                    end
                end
            end

            ST_FILL:
            begin
                mem_we    = 1'b1;
                mem_waddr = idx_reg[AW-1:0];
                idx_next  = idx_reg + 1'b1;
                if (idx_reg == cells_reg - 1'b1)
                begin
                    cursor_next = move_len;
                    row_next    = NW'(rows) - 1'b1;
                    col_next    = '0;
                    state_next  = ST_DONE;
                end
            end

            ST_READ:
            begin
                cell_next  = rdata_reg;
                state_next = ST_DONE;
            end

            ST_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    out_row_next   = row_wide[4:0];
                    out_col_next   = col_wide[6:0];
                    out_scr_next   = scrolled_reg;
                    out_cell_next  = cell_reg;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            cursor_reg    <= '0;
            row_reg       <= '0;
            col_reg       <= '0;
            stale_reg     <= 1'b0;
            scrolled_reg  <= 1'b0;
            idx_reg       <= '0;
            pend_reg      <= 1'b0;
            tab_reg       <= '0;
            div_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cursor_reg    <= cursor_next;
            row_reg       <= row_next;
            col_reg       <= col_next;
            stale_reg     <= stale_next;
            scrolled_reg  <= scrolled_next;
            idx_reg       <= idx_next;
            pend_reg      <= pend_next;
            tab_reg       <= tab_next;
            div_cnt_reg   <= div_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ent_reg      <= ent_next;
        cell_reg     <= cell_next;
        dst_reg      <= dst_next;
        div_q_reg    <= div_q_next;
        div_r_reg    <= div_r_next;
        out_row_reg  <= out_row_next;
        out_col_reg  <= out_col_next;
        out_scr_reg  <= out_scr_next;
        out_cell_reg <= out_cell_next;
        cells_reg    <= NW'(cols) * NW'(rows);
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            screen_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rdata_reg <= screen_mem[mem_raddr];
        end
    end

`ifndef SYNTH
    a_cursor_on_screen: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DONE && ent_reg.op != OP_READ) |-> (cursor_reg < cells_reg))
        else $error("cursor left beyond the screen after a put request");

    a_column_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE && !stale_reg) |-> (col_reg < cols))
        else $error("tracked column not below the column count");

    a_move_only_when_scrolling: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_MOVE || state_reg == ST_FILL) |-> scrolled_reg)
        else $error("screen shift running without a scroll");
`endif

endmodule

/* sv/text_console_teletype.sv */
// A plain put or read request passes the front register, the queue and the back end's
// states up to the done state before its result is offered; a tab also runs the tab
// state, and the first request after a column or row register write runs the divider.
// The back end takes one request at a time and takes another only once it is done; a
// scroll shifts and refills the screen store at one cell per cycle.
// Reset: the whole screen store (MAX_COLUMNS * MAX_ROWS cells) is cleared, no request taken.
module text_console_teletype
    import tct_pkg::*;
#(
    parameter int MAX_COLUMNS = DEFAULT_MAX_COLUMNS,
    parameter int MAX_ROWS    = DEFAULT_MAX_ROWS
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic                   kind,
    input  logic [7:0]             char_code,
    input  logic [7:0]             attribute,
    input  logic [4:0]             read_row,
    input  logic [6:0]             read_column,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [4:0]             cursor_row,
    output logic [6:0]             cursor_column,
    output logic                   scrolled,
    output logic [7:0]             cell_char,
    output logic [7:0]             cell_attribute
);

    localparam int CW = $clog2(MAX_COLUMNS + 1);
    localparam int RW = $clog2(MAX_ROWS + 1);

    logic [7:0]    screen_columns_reg;
    logic [5:0]    screen_rows_reg;
    logic [CW-1:0] cols;
    logic [RW-1:0] rows;
    logic          clearing;
    logic          push_valid;
    logic          push_ready;
    entry_t        push_entry;
    logic          pop_valid;
    logic          pop_ready;
    entry_t        pop_entry;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            screen_columns_reg <= RESET_COLUMNS;
            screen_rows_reg    <= RESET_ROWS;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_SCREEN_COLUMNS: screen_columns_reg <= cfg_data[7:0];
                REG_SCREEN_ROWS:    screen_rows_reg    <= cfg_data[5:0];
                default:            ;
            endcase
        end
    end

    // A size of zero counts as one, and a size above the store counts as the store.
    always_comb
    begin
        if (screen_columns_reg == '0)
        begin
            cols = CW'(1);
        end
        else if (32'(screen_columns_reg) > MAX_COLUMNS)
        begin
            cols = CW'(MAX_COLUMNS);
        end
        else
        begin
            cols = CW'(screen_columns_reg);
        end

        if (screen_rows_reg == '0)
        begin
            rows = RW'(1);
        end
        else if (32'(screen_rows_reg) > MAX_ROWS)
        begin
            rows = RW'(MAX_ROWS);
        end
        else
        begin
            rows = RW'(screen_rows_reg);
        end
    end

    tct_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .clearing    (clearing),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .kind        (kind),
        .char_code   (char_code),
        .attribute   (attribute),
        .read_row    (read_row),
        .read_column (read_column),
        .push_valid  (push_valid),
        .push_ready  (push_ready),
        .push_entry  (push_entry)
    );

    tct_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_entry (push_entry),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_entry  (pop_entry)
    );

    tct_back #(
        .MAX_COLUMNS (MAX_COLUMNS),
        .MAX_ROWS    (MAX_ROWS)
    ) u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_written    (cfg_we),
        .cols           (cols),
        .rows           (rows),
        .pop_valid      (pop_valid),
        .pop_ready      (pop_ready),
        .pop_entry      (pop_entry),
        .clearing       (clearing),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .cursor_row     (cursor_row),
        .cursor_column  (cursor_column),
        .scrolled       (scrolled),
        .cell_char      (cell_char),
        .cell_attribute (cell_attribute)
    );

`ifndef SYNTH
    a_no_request_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
        clearing |-> !in_ready)
        else $error("request taken while the screen store is being cleared");
`endif

endmodule

/* bench/tb.sv */
`timescale 1ns / 100ps

module tb;
    import tct_pkg::*;

    localparam int STORE_CELLS = DEFAULT_MAX_COLUMNS * DEFAULT_MAX_ROWS;

    typedef struct packed {
        logic       kind;
        logic [7:0] char_code;
        logic [7:0] attribute;
        logic [4:0] read_row;
        logic [6:0] read_column;
    } request_t;

    typedef struct packed {
        logic [4:0] cursor_row;
        logic [6:0] cursor_column;
        logic       scrolled;
        logic [7:0] cell_char;
        logic [7:0] cell_attribute;
    } result_t;

    logic                   clk;
    logic                   rst_n = 1'b0;
    logic                   cfg_we = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;
    logic                   in_valid = 1'b0;
    logic                   in_ready;
    request_t               offered = '0;
    logic                   kind;
    logic [7:0]             char_code;
    logic [7:0]             attribute;
    logic [4:0]             read_row;
    logic [6:0]             read_column;
    logic                   out_valid;
    logic                   out_ready = 1'b0;
    logic [4:0]             cursor_row;
    logic [6:0]             cursor_column;
    logic                   scrolled;
    logic [7:0]             cell_char;
    logic [7:0]             cell_attribute;

    assign kind        = offered.kind;
    assign char_code   = offered.char_code;
    assign attribute   = offered.attribute;
    assign read_row    = offered.read_row;
    assign read_column = offered.read_column;

    // Shadow copy of the console state.
    logic [7:0]  model_columns = RESET_COLUMNS;
    logic [5:0]  model_rows    = RESET_ROWS;
    int          cursor_pos    = 0;
    logic [15:0] screen_copy [STORE_CELLS];

    request_t pending_requests [$];
    result_t  due_results [$];

    int     requests_taken    = 0;
    int     requests_retired  = 0;
    int     send_gap          = 0;
    int     stall_left        = 0;
    int     idle_odds         = 4;
    int     long_stall_wanted = 0;
    int     long_stall_served = 0;
    int     mismatch_count    = 0;
    int     random_total      = 0;
    longint cycle_count       = 0;
    longint cycle_limit       = 4 * STORE_CELLS + 20000;

    text_console_teletype u_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .kind           (kind),
        .char_code      (char_code),
        .attribute      (attribute),
        .read_row       (read_row),
        .read_column    (read_column),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .cursor_row     (cursor_row),
        .cursor_column  (cursor_column),
        .scrolled       (scrolled),
        .cell_char      (cell_char),
        .cell_attribute (cell_attribute)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function automatic int active_columns();
        if (model_columns == 0) return 1;
        if (model_columns > DEFAULT_MAX_COLUMNS) return DEFAULT_MAX_COLUMNS;
        return int'(model_columns);
    endfunction

    function automatic int active_rows();
        if (model_rows == 0) return 1;
        if (model_rows > DEFAULT_MAX_ROWS) return DEFAULT_MAX_ROWS;
        return int'(model_rows);
    endfunction

    function automatic void store_cell(int idx, int limit, logic [15:0] value);
        if (idx < limit && idx < STORE_CELLS)
            screen_copy[idx] = value;
    endfunction

    task automatic emulate_console(input request_t rq, output result_t rs);
        int          cols;
        int          rows;
        int          cells;
        int          cur;
        int          row;
        int          col;
        int          k;
        int          idx;
        int          quot;
        int          remd;
        logic [15:0] space;
        cols  = active_columns();
        rows  = active_rows();
        cells = cols * rows;
        rs    = '0;
        if (rq.kind == KIND_READ)
        begin
            if (int'(rq.read_row) < rows && int'(rq.read_column) < cols)
            begin
                idx = int'(rq.read_row) * cols + int'(rq.read_column);
                rs.cell_char      = screen_copy[idx][7:0];
                rs.cell_attribute = screen_copy[idx][15:8];
            end
        end
        else
        begin
            cur   = cursor_pos;
            row   = cur / cols;
            col   = cur % cols;
            space = {rq.attribute, CHAR_SPACE};
            case (rq.char_code)
                CHAR_LINE_FEED:       cur = (row + 1) * cols + col;
                CHAR_CARRIAGE_RETURN: cur = row * cols;
                CHAR_BACKSPACE:       if (col > 0) cur--;
                CHAR_TAB:
                begin
                    for (k = 0; k < TAB_CELLS; k++)
                        store_cell(cur + k, cells, space);
                    cur += TAB_CELLS;
                end
                default:
                begin
                    store_cell(cur, cells, {rq.attribute, rq.char_code});
                    cur++;
                end
            endcase
            if (cur >= cells)
            begin
                // Scroll up one row; the copy runs forward, so overlap is harmless.
                for (k = 0; k < cols * (rows - 1); k++)
                    screen_copy[k] = screen_copy[k + cols];
                for (k = 0; k < cols; k++)
                    store_cell(cols * (rows - 1) + k, cells, space);
                cur = cols * (rows - 1);
                rs.scrolled = 1'b1;
            end
            cursor_pos = cur;
        end
        quot = cursor_pos / cols;
        remd = cursor_pos % cols;
        rs.cursor_row    = quot[4:0];
        rs.cursor_column = remd[6:0];
    endtask

    function automatic void report_mismatch(string what, int want, int got);
        mismatch_count++;
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
    endfunction

    // Sender: one request at a time from the pending queue, with random gaps.
    always @(negedge clk)
    begin
        logic     v;
        request_t rq;
        v  = in_valid;
        rq = offered;
        if (in_valid && requests_taken != requests_retired)
        begin
            requests_retired = requests_taken;
            v = 1'b0;
            if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1)
                send_gap = $urandom_range(1, 10);
        end
        if (!v)
        begin
            if (send_gap > 0)
                send_gap--;
            else if (pending_requests.size() > 0)
            begin
                rq = pending_requests.pop_front();
                v  = 1'b1;
            end
        end
        in_valid <= v;
        offered  <= rq;
    end

    // Receiver: random stalls, plus a long hold-off when one is asked for.
    always @(negedge clk)
    begin
        logic r;
        if (stall_left == 0)
        begin
            if (long_stall_wanted != long_stall_served)
            begin
                long_stall_served = long_stall_wanted;
                stall_left = 400;
            end
            else if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1)
                stall_left = $urandom_range(1, 10);
        end
        if (stall_left > 0)
        begin
            stall_left--;
            r = 1'b0;
        end
        else
            r = 1'b1;
        out_ready <= r;
    end

    always @(posedge clk)
    begin
        result_t got;
        result_t want;
        result_t fresh;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                got = {cursor_row, cursor_column, scrolled, cell_char, cell_attribute};
                if (due_results.size() == 0)
                begin
                    mismatch_count++;
                    $display("%0t: unexpected result, expected none, got row %0d column %0d char %0d",
                             $time, got.cursor_row, got.cursor_column, got.cell_char);
                end
                else
                begin
                    want = due_results.pop_front();
                    if (got.cursor_row !== want.cursor_row)
                        report_mismatch("cursor_row", int'(want.cursor_row),
                                        int'(got.cursor_row));
                    if (got.cursor_column !== want.cursor_column)
                        report_mismatch("cursor_column", int'(want.cursor_column),
                                        int'(got.cursor_column));
                    if (got.scrolled !== want.scrolled)
                        report_mismatch("scrolled", int'(want.scrolled), int'(got.scrolled));
                    if (got.cell_char !== want.cell_char)
                        report_mismatch("cell_char", int'(want.cell_char),
                                        int'(got.cell_char));
                    if (got.cell_attribute !== want.cell_attribute)
                        report_mismatch("cell_attribute", int'(want.cell_attribute),
                                        int'(got.cell_attribute));
                end
            end
            if (in_valid && in_ready)
            begin
                emulate_console(offered, fresh);
                due_results.push_back(fresh);
                requests_taken++;
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > cycle_limit)
        begin
            $display("%0t: timed out with %0d results outstanding", $time, due_results.size());
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    task automatic queue_request(input logic k, input logic [7:0] ch, input logic [7:0] attr,
                                 input logic [4:0] row, input logic [6:0] col);
        request_t rq;
        rq = '{kind: k, char_code: ch, attribute: attr, read_row: row, read_column: col};
        pending_requests.push_back(rq);
        // A scroll walks the whole screen, so allow one per request.
        cycle_limit += 4 * (active_columns() * active_rows() + 60);
    endtask

    task automatic queue_random_request();
        int         pick;
        logic [7:0] ch;
        logic [4:0] row;
        logic [6:0] col;
        pick = $urandom_range(0, 99);
        ch   = 8'($urandom_range(0, 255));
        row  = 5'($urandom_range(0, 31));
        col  = 7'($urandom_range(0, 127));
        if (pick < 20)
        begin
            // Mostly reads inside the screen, some anywhere.
            if ($urandom_range(0, 9) < 7)
            begin
                row = 5'($urandom_range(0, active_rows() - 1));
                col = 7'($urandom_range(0, active_columns() - 1));
            end
            queue_request(KIND_READ, ch, 8'($urandom_range(0, 255)), row, col);
        end
        else
        begin
            if (pick < 35)
                ch = CHAR_LINE_FEED;
            else if (pick < 43)
                ch = CHAR_CARRIAGE_RETURN;
            else if (pick < 51)
                ch = CHAR_BACKSPACE;
            else if (pick < 59)
                ch = CHAR_TAB;
            queue_request(KIND_PUT, ch, 8'($urandom_range(0, 255)), row, col);
        end
    endtask

    task automatic wait_drained();
        while (pending_requests.size() != 0 || in_valid || due_results.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_register(input logic [CFG_INDEX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] data);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = data;
        if (idx == REG_SCREEN_COLUMNS)
            model_columns = data;
        else
            model_rows = data[5:0];
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    task automatic run_phase(input int cols, input int rows, input int count, input int odds,
                             input bit long_hold);
        wait_drained();
        write_register(REG_SCREEN_COLUMNS, CFG_DATA_W'(cols));
        write_register(REG_SCREEN_ROWS, CFG_DATA_W'(rows));
        idle_odds = odds;
        if (long_hold)
        begin
            long_stall_wanted++;
            cycle_limit += 2000;
        end
        repeat (count) queue_random_request();
        random_total += count;
    endtask

    initial
    begin
        repeat (6) @(negedge clk);
        rst_n = 1'b1;

        // The store is cleared after reset; the block takes nothing until then.
        while (!in_ready) @(negedge clk);

        // Reset geometry first.
        repeat (12) queue_random_request();
        wait_drained();

        // Directed requests on a 4 x 2 screen.
        write_register(REG_SCREEN_COLUMNS, 8'd4);
        write_register(REG_SCREEN_ROWS, 8'd2);
        idle_odds = 3;
        queue_request(KIND_PUT, 8'h41, 8'hFF, 5'd0, 7'd0);
        queue_request(KIND_PUT, CHAR_CARRIAGE_RETURN, 8'h00, 5'd0, 7'd0);
        queue_request(KIND_PUT, 8'h00, 8'h00, 5'd0, 7'd0);
        queue_request(KIND_PUT, 8'hFF, 8'hA5, 5'd31, 7'd127);
        queue_request(KIND_PUT, CHAR_BACKSPACE, 8'h11, 5'd0, 7'd0);
        queue_request(KIND_PUT, CHAR_CARRIAGE_RETURN, 8'h22, 5'd0, 7'd0);
        queue_request(KIND_PUT, CHAR_BACKSPACE, 8'h33, 5'd0, 7'd0);
        queue_request(KIND_PUT, CHAR_TAB, 8'h44, 5'd0, 7'd0);
        queue_request(KIND_PUT, CHAR_LINE_FEED, 8'h55, 5'd0, 7'd0);
        queue_request(KIND_PUT, CHAR_LINE_FEED, 8'h66, 5'd0, 7'd0);
        queue_request(KIND_PUT, 8'h78, 8'h77, 5'd0, 7'd0);
        queue_request(KIND_PUT, CHAR_TAB, 8'h88, 5'd0, 7'd0);
        queue_request(KIND_PUT, 8'h79, 8'h99, 5'd0, 7'd0);
        queue_request(KIND_PUT, 8'h7E, 8'h5A, 5'd0, 7'd0);
        queue_request(KIND_PUT, 8'h7F, 8'hC3, 5'd0, 7'd0);
        queue_request(KIND_READ, 8'h00, 8'h00, 5'd0, 7'd0);
        queue_request(KIND_READ, 8'hFF, 8'hFF, 5'd1, 7'd3);
        queue_request(KIND_READ, 8'h00, 8'h00, 5'd0, 7'd1);
        queue_request(KIND_READ, 8'h00, 8'h00, 5'd2, 7'd0);
        queue_request(KIND_READ, 8'h00, 8'h00, 5'd0, 7'd4);
        queue_request(KIND_READ, 8'h00, 8'h00, 5'd31, 7'd127);
        queue_request(KIND_PUT, CHAR_CARRIAGE_RETURN, 8'hE7, 5'd0, 7'd0);
        queue_request(KIND_PUT, CHAR_TAB, 8'h18, 5'd0, 7'd0);
        queue_request(KIND_READ, 8'h00, 8'h00, 5'd1, 7'd0);

        // Geometry sweep, extremes and out-of-range sizes included.
        run_phase(1, 1, 60, 4, 1'b0);
        run_phase(128, 32, 30, 4, 1'b0);
        run_phase(0, 0, 40, 2, 1'b0);
        run_phase(255, 8'hFF, 20, 0, 1'b0);
        run_phase(129, 33, 20, 3, 1'b0);
        run_phase(8, 4, 100, 4, 1'b1);
        run_phase(2, 3, 80, 2, 1'b0);
        run_phase(16, 8, 80, 0, 1'b0);
        run_phase(40, 2, 60, 6, 1'b0);
        run_phase(1, 32, 80, 3, 1'b0);
        run_phase(128, 1, 60, 4, 1'b0);
        run_phase(3, 8'hC1, 60, 2, 1'b0);

        while (random_total < 1640)
            run_phase($urandom_range(1, 12), $urandom_range(1, 6) | ($urandom_range(0, 3) << 6),
                      80, $urandom_range(0, 3) * 2, 1'b0);

        // Closing stretch at full speed on both sides.
        run_phase(5, 3, 100, 0, 1'b0);
        run_phase(128, 2, 60, 0, 1'b0);

        wait_drained();
        repeat (50) @(negedge clk);
        if (mismatch_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

/* files.f */
sv/tct_pkg.sv
sv/tct_front.sv
sv/tct_queue.sv
sv/tct_back.sv
sv/text_console_teletype.sv
bench/tb.sv
